// ===== rtl/maft_pkg.sv =====
`timescale 1ns / 1ps
// types and constants shared by the mac address filter table
// no dependencies

package maft_pkg;

   localparam int MacWidth   = 48;
   localparam int IndexWidth = 5;
   localparam int TableDepth = 32;

   localparam logic [IndexWidth-1:0] StationEntry = 5'd31;

   localparam logic [1:0] OpInsert  = 2'd0;
   localparam logic [1:0] OpDelete  = 2'd1;
   localparam logic [1:0] OpStation = 2'd2;
   localparam logic [1:0] OpRead    = 2'd3;

   typedef struct packed {
      logic [1:0]            opcode;
      logic [MacWidth-1:0]   mac_address;
      logic [IndexWidth-1:0] entry_index;
   } maft_req_type;

   typedef struct packed {
      logic                  status;
      logic [IndexWidth-1:0] slot;
      logic                  slot_valid;
      logic [MacWidth-1:0]   slot_address;
   } maft_rsp_type;

   typedef struct packed {
      logic                valid;
      logic [MacWidth-1:0] mac;
   } maft_entry_type;

   typedef struct packed {
      logic free;
      logic match;
   } maft_flags_type;

   typedef struct packed {
      logic           shift;
      maft_entry_type tail;
   } maft_ring_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } maft_state_type;

endpackage

// ===== rtl/maft_cell.sv =====
`timescale 1ns / 1ps
// one table entry of the rotating ring, with its free and match flags
// depends on maft_pkg

module maft_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         shift,
   input  maft_pkg::maft_entry_type     entry_i,
   input  logic [maft_pkg::MacWidth-1:0] key,
   output maft_pkg::maft_entry_type     entry_o,
   output maft_pkg::maft_flags_type     flags_o
);

   logic                          valid_ff;
   logic                          valid_in;
   logic [maft_pkg::MacWidth-1:0] mac_ff;
   logic [maft_pkg::MacWidth-1:0] mac_in;

   assign valid_in = shift ? entry_i.valid : valid_ff;
   assign mac_in   = shift ? entry_i.mac : mac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mac_ff <= mac_in;
   end

   // an invalid entry always reads as address zero
   assign entry_o.valid = valid_ff;
   assign entry_o.mac   = valid_ff ? mac_ff : '0;

   assign flags_o.free  = ~valid_ff;
   assign flags_o.match = valid_ff && (mac_ff == key);

endmodule

// ===== rtl/maft_ctrl.sv =====
`timescale 1ns / 1ps
// operation sequencer: rewrites the head of the ring and builds the result
// depends on maft_pkg

module maft_ctrl #(
   parameter int FREE_ENTRIES = 31
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  maft_pkg::maft_req_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output maft_pkg::maft_rsp_type        rsp_data,
   input  maft_pkg::maft_entry_type      head_entry,
   input  maft_pkg::maft_flags_type      head_flags,
   output logic [maft_pkg::MacWidth-1:0] scan_key,
   output maft_pkg::maft_ring_ctl_type   ring_ctl
);

   localparam int LimitInt = (FREE_ENTRIES < 31) ? FREE_ENTRIES : 31;
   localparam logic [maft_pkg::IndexWidth-1:0] ScanLimit = maft_pkg::IndexWidth'(LimitInt);

   maft_pkg::maft_state_type state_ff, state_in;

   logic [maft_pkg::IndexWidth-1:0] count_ff, count_in;
   logic [1:0]                      op_ff;
   logic [maft_pkg::MacWidth-1:0]   mac_ff;
   logic [maft_pkg::IndexWidth-1:0] index_ff;
   logic                            found_ff, found_in;
   logic [maft_pkg::IndexWidth-1:0] res_slot_ff;
   maft_pkg::maft_entry_type        res_entry_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   maft_pkg::maft_rsp_type          rsp_ff;

   logic                     accept;
   logic                     rsp_free;
   logic                     load_rsp;
   logic                     scanning;
   logic                     in_scan;
   logic                     hit;
   maft_pkg::maft_entry_type new_entry;

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign in_scan  = count_ff < ScanLimit;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         maft_pkg::ST_IDLE: begin
            if (req_valid) state_in = maft_pkg::ST_SCAN;
         end
         maft_pkg::ST_SCAN: begin
            if (count_ff == '1) state_in = maft_pkg::ST_FINISH;
         end
         maft_pkg::ST_FINISH: begin
            if (rsp_free) state_in = maft_pkg::ST_IDLE;
         end
         default: state_in = maft_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      scanning  = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         maft_pkg::ST_IDLE:   req_stall = 1'b0;
         maft_pkg::ST_SCAN:   scanning  = 1'b1;
         maft_pkg::ST_FINISH: load_rsp  = rsp_free;
         default:             req_stall = 1'b1;
      endcase
   end

   // decision on the entry now at the head of the ring
   always_comb begin
      hit       = 1'b0;
      new_entry = head_entry;
      case (op_ff)
         maft_pkg::OpInsert: begin
            hit             = !found_ff && in_scan && head_flags.free;
            new_entry.valid = 1'b1;
            new_entry.mac   = mac_ff;
         end
         maft_pkg::OpDelete: begin
            hit       = !found_ff && in_scan && head_flags.match;
            new_entry = '0;
         end
         maft_pkg::OpStation: begin
            hit             = (count_ff == maft_pkg::StationEntry);
            new_entry.valid = 1'b1;
            new_entry.mac   = mac_ff;
         end
         default: begin
            hit = (count_ff == index_ff);
         end
      endcase
   end

   assign ring_ctl.shift = scanning;
   assign ring_ctl.tail  = (scanning && hit) ? new_entry : head_entry;
   assign scan_key       = mac_ff;

   assign count_in     = accept ? '0 : (scanning ? count_ff + 1'b1 : count_ff);
   assign found_in     = accept ? 1'b0 : (found_ff || (scanning && hit));
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= maft_pkg::ST_IDLE;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff        <= req_data.opcode;
         mac_ff       <= req_data.mac_address;
         index_ff     <= req_data.entry_index;
         res_slot_ff  <= '0;
         res_entry_ff <= '0;
      end else if (scanning && hit) begin
         res_slot_ff  <= count_ff;
         res_entry_ff <= ring_ctl.tail;
      end
      if (load_rsp) begin
         rsp_ff.status       <= ~found_ff;
         rsp_ff.slot         <= res_slot_ff;
         rsp_ff.slot_valid   <= res_entry_ff.valid;
         rsp_ff.slot_address <= res_entry_ff.mac;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == maft_pkg::ST_SCAN) && (count_ff == '0))
      else $error("scan did not start at step zero");

   a_full_lap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == maft_pkg::ST_SCAN) && (count_ff != '1) |=> state_ff == maft_pkg::ST_SCAN)
      else $error("scan left before the ring came full circle");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == maft_pkg::ST_FINISH)
      else $error("result shown without a finished scan");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status |->
         (rsp_ff.slot == '0) && !rsp_ff.slot_valid && (rsp_ff.slot_address == '0))
      else $error("failed item carries nonzero fields");

endmodule

// ===== rtl/mac_address_filter_table.sv =====
`timescale 1ns / 1ps
// top level of the destination mac address filter table
// depends on maft_pkg, maft_cell and maft_ctrl

// The table of 32 entries (valid bit and 48-bit address) lives in a ring of
// 32 cells. Every operation turns the ring once in a lap of 32 steps: at
// each step every cell hands its entry to its neighbor, and the entry
// passing the head is checked and, where the operation calls for it,
// rewritten before it goes back in at the tail. After the lap each entry
// sits in its home cell again. The result of an item is loaded into the
// output register after its lap, and no new item is accepted before that.
// req_stall is high while a lap is under way and until the result has a
// place in the output register; one result waits there without holding up
// the next item. Insert takes the lowest free entry below the scan limit
// (FREE_ENTRIES, at most 31), delete clears the lowest valid entry below
// that limit with an equal address, station writes entry 31, read reports
// any entry. Reset clears the valid bits at once; an invalid entry always
// reads as address zero, so no clearing pass is needed.

module mac_address_filter_table #(
   parameter int FREE_ENTRIES = 31
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  maft_pkg::maft_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output maft_pkg::maft_rsp_type rsp_data
);

   // cell k holds the entry that is k steps from the head
   maft_pkg::maft_entry_type    cell_out [maft_pkg::TableDepth];
   maft_pkg::maft_flags_type    head_flags;
   maft_pkg::maft_ring_ctl_type ring_ctl;
   logic [maft_pkg::MacWidth-1:0] scan_key;

   for (genvar k = 0; k < maft_pkg::TableDepth; k++) begin : g_ring
      maft_pkg::maft_entry_type cell_in;

      // the last cell takes the head entry back, possibly rewritten
      if (k == maft_pkg::TableDepth - 1) begin : g_tail
         assign cell_in = ring_ctl.tail;
      end else begin : g_body
         assign cell_in = cell_out[k+1];
      end

      // only the head cell's flags drive decisions
      if (k == 0) begin : g_head
         maft_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (ring_ctl.shift),
            .entry_i (cell_in),
            .key     (scan_key),
            .entry_o (cell_out[k]),
            .flags_o (head_flags)
         );
      end else begin : g_other
         maft_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (ring_ctl.shift),
            .entry_i (cell_in),
            .key     (scan_key),
            .entry_o (cell_out[k]),
            .flags_o ()
         );
      end
   end

   // sequencer: walks the lap, rewrites the head, holds the result
   maft_ctrl #(
      .FREE_ENTRIES (FREE_ENTRIES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .head_entry (cell_out[0]),
      .head_flags (head_flags),
      .scan_key   (scan_key),
      .ring_ctl   (ring_ctl)
   );

endmodule

// ===== tb/maft_checker.sv =====
`timescale 1ns / 1ps
// checker for the mac address filter table: shadow table, expected results and compare
// depends on maft_pkg

module maft_checker
   import maft_pkg::*;
#(
   parameter int FREE_ENTRIES = 31
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  maft_req_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  maft_rsp_type rsp_data,
   output int           failures,
   output int           outstanding
);

   localparam int ScanLimit = (FREE_ENTRIES < 31) ? FREE_ENTRIES : 31;

   logic                shadow_valid [TableDepth];
   logic [MacWidth-1:0] shadow_mac   [TableDepth];
   maft_rsp_type        pending_results [$];

   function automatic maft_rsp_type entry_report(input int idx);
      maft_rsp_type rsp;
      rsp.status       = 1'b0;
      rsp.slot         = idx[IndexWidth-1:0];
      rsp.slot_valid   = shadow_valid[idx];
      rsp.slot_address = shadow_mac[idx];
      return rsp;
   endfunction

   // applies one operation to the shadow table and returns its result
   function automatic maft_rsp_type apply_filter_op(input maft_req_type item);
      maft_rsp_type rsp;
      bit           done;
      int           i;
      rsp        = '0;
      rsp.status = 1'b1;
      done       = 1'b0;
      case (item.opcode)
         OpInsert: begin
            for (i = 0; i < ScanLimit; i++) begin
               if (!done && !shadow_valid[i]) begin
                  shadow_valid[i] = 1'b1;
                  shadow_mac[i]   = item.mac_address;
                  rsp  = entry_report(i);
                  done = 1'b1;
               end
            end
         end
         OpDelete: begin
            for (i = 0; i < ScanLimit; i++) begin
               if (!done && shadow_valid[i] && shadow_mac[i] == item.mac_address) begin
                  shadow_valid[i] = 1'b0;
                  shadow_mac[i]   = '0;
                  rsp  = entry_report(i);
                  done = 1'b1;
               end
            end
         end
         OpStation: begin
            shadow_valid[StationEntry] = 1'b1;
            shadow_mac[StationEntry]   = item.mac_address;
            rsp = entry_report(int'(StationEntry));
         end
         default: begin
            rsp = entry_report(int'(item.entry_index));
         end
      endcase
      return rsp;
   endfunction

   task automatic report_mismatch(input string what, input maft_rsp_type want,
                                  input maft_rsp_type got);
      failures++;
      if (failures <= 10) begin
         $display("%0t %s: expected status %0d slot %0d valid %0d addr %012h", $time, what,
                  want.status, want.slot, want.slot_valid, want.slot_address);
         $display("%0t %s:      got status %0d slot %0d valid %0d addr %012h", $time, what,
                  got.status, got.slot, got.slot_valid, got.slot_address);
      end
   endtask

   always @(posedge clock) begin
      maft_rsp_type want;
      int           i;
      if (reset) begin
         pending_results.delete();
         for (i = 0; i < TableDepth; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_mac[i]   = '0;
         end
      end else begin
         // results first, so an item accepted on the same edge queues behind
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result", '0, rsp_data);
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.status !== want.status || rsp_data.slot !== want.slot ||
                   rsp_data.slot_valid !== want.slot_valid ||
                   rsp_data.slot_address !== want.slot_address) begin
                  report_mismatch("result mismatch", want, rsp_data);
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_results.push_back(apply_filter_op(req_data));
         end
      end
      outstanding = pending_results.size();
   end

endmodule

// ===== tb/mac_address_filter_table_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the mac address filter table: clock, reset, stimulus and verdict
// depends on maft_pkg, maft_checker and the mac_address_filter_table rtl

module mac_address_filter_table_tb;
   import maft_pkg::*;

   localparam int FreeEntries  = 31;
   localparam int RandomItems  = 600;
   localparam int CalmItems    = 80;   // tail of the run with no idling on either side
   localparam int HoldAfter    = 200;  // item count that triggers the long result hold-off
   localparam int HoldCycles   = 300;
   localparam int SettleCycles = 40;   // room for a full lap and the output register load, with margin
   localparam int PoolSize     = 16;

   // shapes of the random rounds
   localparam int ModeFill  = 0;
   localparam int ModeDrain = 1;
   localparam int ModeMixed = 2;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   maft_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   maft_rsp_type rsp_data;

   int failures;
   int outstanding;
   int items_sent  = 0;
   int random_sent = 0;
   bit calm        = 1'b0;

   logic [MacWidth-1:0] address_pool [PoolSize];

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   mac_address_filter_table #(
      .FREE_ENTRIES(FreeEntries)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   maft_checker #(
      .FREE_ENTRIES(FreeEntries)
   ) checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .failures   (failures),
      .outstanding(outstanding)
   );

   function automatic logic [MacWidth-1:0] random_mac();
      logic [31:0] hi;
      logic [31:0] lo;
      hi = $urandom;
      lo = $urandom;
      return {hi[15:0], lo};
   endfunction

   function automatic maft_req_type op_item(input logic [1:0] op,
                                            input logic [MacWidth-1:0] mac,
                                            input logic [IndexWidth-1:0] idx);
      maft_req_type item;
      item.opcode      = op;
      item.mac_address = mac;
      item.entry_index = idx;
      return item;
   endfunction

   // random item; pool addresses mostly, so deletes find what inserts put in
   function automatic maft_req_type random_item(input int mode);
      maft_req_type item;
      int           pick;
      pick = $urandom_range(0, 9);
      case (mode)
         ModeFill:  item.opcode = (pick < 8) ? OpInsert : ((pick == 8) ? OpDelete : OpRead);
         ModeDrain: item.opcode = (pick < 8) ? OpDelete : ((pick == 8) ? OpInsert : OpRead);
         default:   item.opcode = 2'($urandom_range(0, 3));
      endcase
      if ($urandom_range(0, 7) == 0) begin
         item.mac_address = random_mac();
      end else begin
         item.mac_address = address_pool[$urandom_range(0, PoolSize - 1)];
      end
      item.entry_index = IndexWidth'($urandom_range(0, 31));
      return item;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(input maft_req_type item);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   // sender goes quiet until every expected result has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   // result side: random stall bursts, one long hold-off so the block backs up
   initial begin : result_side
      bit held;
      held = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (!held && items_sent >= HoldAfter) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(negedge clock);
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [MacWidth-1:0] addr_a;
      logic [MacWidth-1:0] addr_b;
      logic [MacWidth-1:0] addr_c;
      int                  mode;
      int                  len;
      int                  k;

      address_pool[0] = '0;
      address_pool[1] = '1;
      for (k = 2; k < PoolSize; k++) begin
         address_pool[k] = random_mac();
      end
      addr_a = address_pool[2];
      addr_b = address_pool[3];
      addr_c = random_mac();

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, zero and all-ones addresses, duplicates,
      // slot reuse, not found, station overwrite, station never deleted
      send_item(op_item(OpRead,    '0,     5'd0));
      send_item(op_item(OpRead,    '1,     5'd31));
      send_item(op_item(OpDelete,  '0,     5'd31));  // zero address, no valid entry
      send_item(op_item(OpInsert,  '0,     5'd31));
      send_item(op_item(OpInsert,  '1,     5'd0));
      send_item(op_item(OpInsert,  addr_a, 5'd7));
      send_item(op_item(OpInsert,  '1,     5'd0));   // same address twice
      send_item(op_item(OpDelete,  '1,     5'd0));   // lowest of the two goes
      send_item(op_item(OpRead,    '0,     5'd1));
      send_item(op_item(OpInsert,  addr_b, 5'd0));   // reuses the freed slot
      send_item(op_item(OpDelete,  '0,     5'd0));   // zero address on a valid entry
      send_item(op_item(OpDelete,  addr_c, 5'd0));   // not found
      send_item(op_item(OpStation, '1,     5'd0));
      send_item(op_item(OpStation, '0,     5'd5));   // overwrites the station entry
      send_item(op_item(OpDelete,  '0,     5'd0));   // station entry stays
      send_item(op_item(OpRead,    '1,     5'd31));
      send_item(op_item(OpRead,    '0,     5'd30));
      send_item(op_item(OpStation, addr_a, 5'd31));
      send_item(op_item(OpDelete,  addr_a, 5'd0));   // free entry, not the station one
      send_item(op_item(OpDelete,  addr_a, 5'd0));   // only the station entry is left
      send_item(op_item(OpRead,    '0,     5'd31));
      send_item(op_item(OpRead,    '0,     5'd3));
      wait_for_drain();

      // fill well past capacity so the full-table case is hit
      for (k = 0; k < 34; k++) begin
         send_item(op_item(OpInsert, address_pool[$urandom_range(0, PoolSize - 1)],
                           IndexWidth'($urandom_range(0, 31))));
         random_sent++;
      end
      wait_for_drain();

      // random rounds of fill, drain and mixed traffic
      while (random_sent < RandomItems) begin
         mode = $urandom_range(ModeFill, ModeMixed);
         len  = $urandom_range(4, 40);
         for (k = 0; k < len && random_sent < RandomItems; k++) begin
            calm = (random_sent >= RandomItems - CalmItems);
            send_item(random_item(mode));
            random_sent++;
         end
         if (!calm && $urandom_range(0, 7) == 0) begin
            wait_for_drain();
         end
      end

      // all items in: wait for the last results, then let the block settle
      wait_for_drain();
      repeat (SettleCycles) @(negedge clock);

      if (failures == 0 && outstanding == 0) begin
         $display("[mac_address_filter_table] OK");
      end else begin
         $display("[mac_address_filter_table] ERROR");
      end
      $finish;
   end

   // hang guard, far above the slowest correct run
   initial begin : watchdog
      #2_000_000;
      $display("[mac_address_filter_table] ERROR");
      $finish;
   end

endmodule
